@@ design/cspl_pkg.sv @@
package cspl_pkg;

  localparam int IN_W        = 16;
  localparam int PT_W        = IN_W + 2;
  localparam int OUT_W       = 20;
  localparam int TENS_W      = 15;
  localparam int SPS_W       = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 15;
  localparam int HW          = 56;
  localparam int MW          = HW - 10;
  localparam int QB          = 21;
  localparam int JQ_DEPTH    = 2;
  localparam int DEF_MAX_SAMPLES = 32;
  localparam int GRAIN_CAP   = 32;

  localparam logic [TENS_W-1:0] DEF_TENSION = TENS_W'(8192);
  localparam logic [SPS_W-1:0]  DEF_SAMPLES = SPS_W'(16);
  localparam logic              DEF_REFLECT = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TENSION = 2'd0,
    CFG_SAMPLES = 2'd1,
    CFG_REFLECT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [IN_W-1:0] point_x;
    logic signed [IN_W-1:0] point_y;
    logic                   last_point;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] curve_x;
    logic signed [OUT_W-1:0] curve_y;
    logic                    run_end;
  } out_word_t;

  typedef logic signed [PT_W-1:0] coord_t;

  typedef struct packed {
    coord_t a;
    coord_t b;
    coord_t c;
    coord_t d;
  } pts_t;

  typedef struct packed {
    logic point;
    logic last;
    pts_t xp;
    pts_t yp;
  } job_t;

  typedef struct packed {
    logic [TENS_W-1:0] tension;
    logic [SPS_W-1:0]  samples;
    logic              reflect;
  } cfg_t;

  typedef enum logic [3:0] {
    LANE_HOLD,
    LANE_LOAD,
    LANE_C1,
    LANE_C2,
    LANE_C3,
    LANE_K2,
    LANE_K3,
    LANE_K4,
    LANE_H0,
    LANE_H1,
    LANE_H2,
    LANE_DINIT,
    LANE_DSTEP
  } lane_op_t;

  typedef struct packed {
    lane_op_t          op;
    logic              point;
    logic [TENS_W-1:0] tension;
    logic [SPS_W-1:0]  j;
    logic [SPS_W-1:0]  grain;
    logic [10:0]       g2;
    logic [15:0]       g3;
  } lane_ctl_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SETUP,
    B_HORN,
    B_DINIT,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

@@ design/cspl_jobq.sv @@
module cspl_jobq import cspl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_word,
  output logic full,
  input  logic pop,
  output job_t head_word,
  output logic empty
);

  localparam int PW = (JQ_DEPTH > 1) ? $clog2(JQ_DEPTH) : 1;
  localparam int CW = $clog2(JQ_DEPTH + 1);

  job_t            mem_r [JQ_DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full      = (cnt_r == CW'(JQ_DEPTH));
  assign empty     = (cnt_r == '0);
  assign head_word = mem_r[rd_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(JQ_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(JQ_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_word;
    end
  end

endmodule

@@ design/cspl_front.sv @@
module cspl_front import cspl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_word_t in_word,
  output logic     in_full,
  input  logic     reflect,
  output logic     jq_push,
  output job_t     jq_word,
  input  logic     jq_full
);

  logic signed [IN_W-1:0] rx_r [3];
  logic signed [IN_W-1:0] ry_r [3];
  logic [1:0] seen_r, seen_nxt;
  logic [1:0] pend_r, pend_nxt;
  job_t       job0_r, job1_r, job0_nxt, job1_nxt;
  job_t       nj0, nj1;
  logic [1:0] njobs;
  logic       accept, last;
  coord_t     x, y, r0x, r0y, r1x, r1y, r2x, r2y;
  coord_t     fgx, fgy, bgx2, bgy2, bgx3, bgy3;

  assign in_full = (pend_r != 2'd0);
  assign accept  = in_push && !in_full;
  assign last    = in_word.last_point;
  assign jq_push = (pend_r != 2'd0);
  assign jq_word = job0_r;

  assign x   = PT_W'(in_word.point_x);
  assign y   = PT_W'(in_word.point_y);
  assign r0x = PT_W'(rx_r[0]);
  assign r0y = PT_W'(ry_r[0]);
  assign r1x = PT_W'(rx_r[1]);
  assign r1y = PT_W'(ry_r[1]);
  assign r2x = PT_W'(rx_r[2]);
  assign r2y = PT_W'(ry_r[2]);

  // ghost points: reflected when reflect is set, else a copy of the end point
  assign fgx  = reflect ? x + r1x - r2x : r1x;
  assign fgy  = reflect ? y + r1y - r2y : r1y;
  assign bgx2 = reflect ? x - r2x + r1x : x;
  assign bgy2 = reflect ? y - r2y + r1y : y;
  assign bgx3 = bgx2;
  assign bgy3 = bgy2;

  always_comb begin
    nj0      = '0;
    nj1      = '0;
    njobs    = 2'd0;
    seen_nxt = last ? 2'd0 : ((seen_r == 2'd3) ? 2'd3 : seen_r + 2'd1);
    unique case (seen_r)
      2'd0: begin
        njobs = 2'd0;
      end
      2'd1: begin
        nj0.point = 1'b1;
        nj0.last  = !last;
        nj0.xp    = '{r2x, r2x, r2x, r2x};
        nj0.yp    = '{r2y, r2y, r2y, r2y};
        nj1.point = 1'b0;
        nj1.last  = 1'b1;
        nj1.xp    = '{r2x, r2x, x, x};
        nj1.yp    = '{r2y, r2y, y, y};
        njobs     = last ? 2'd2 : 2'd1;
      end
      2'd2: begin
        nj0.last  = !last;
        nj0.xp    = '{fgx, r1x, r2x, x};
        nj0.yp    = '{fgy, r1y, r2y, y};
        nj1.last  = 1'b1;
        nj1.xp    = '{r1x, r2x, x, bgx2};
        nj1.yp    = '{r1y, r2y, y, bgy2};
        njobs     = last ? 2'd2 : 2'd1;
      end
      default: begin
        nj0.last  = !last;
        nj0.xp    = '{r0x, r1x, r2x, x};
        nj0.yp    = '{r0y, r1y, r2y, y};
        nj1.last  = 1'b1;
        nj1.xp    = '{r1x, r2x, x, bgx3};
        nj1.yp    = '{r1y, r2y, y, bgy3};
        njobs     = last ? 2'd2 : 2'd1;
      end
    endcase
  end

  always_comb begin
    pend_nxt = pend_r;
    job0_nxt = job0_r;
    job1_nxt = job1_r;
    if (accept) begin
      pend_nxt = njobs;
      job0_nxt = nj0;
      job1_nxt = nj1;
    end else if (jq_push && !jq_full) begin
      pend_nxt = pend_r - 2'd1;
      job0_nxt = job1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 2'd0;
      pend_r <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        rx_r[i] <= '0;
        ry_r[i] <= '0;
      end
    end else begin
      pend_r <= pend_nxt;
      if (accept) begin
        seen_r  <= seen_nxt;
        rx_r[0] <= rx_r[1];
        rx_r[1] <= rx_r[2];
        rx_r[2] <= in_word.point_x;
        ry_r[0] <= ry_r[1];
        ry_r[1] <= ry_r[2];
        ry_r[2] <= in_word.point_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    job0_r <= job0_nxt;
    job1_r <= job1_nxt;
  end

endmodule

@@ design/cspl_lane.sv @@
module cspl_lane import cspl_pkg::*; (
  input  logic                    clk,
  input  lane_ctl_t               ctl,
  input  pts_t                    pts_in,
  output logic signed [OUT_W-1:0] res
);

  localparam logic signed [QB+1:0] SMAX = (QB+2)'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [QB+1:0] SMIN = -SMAX - (QB+2)'(1);
  localparam logic signed [OUT_W-1:0] OMAX = OUT_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [OUT_W-1:0] OMIN = -OMAX - OUT_W'(1);

  coord_t a_r, b_r, c_r, d_r;
  logic signed [HW-1:0] c1_r, c2_r, c3_r, k2_r, k3_r, k4_r, h_r;
  logic [MW-1:0] rem_r, dsr_r;
  logic [QB-1:0] q_r;
  logic          neg_r, ovf_r;

  logic signed [HW-1:0]    ea, eb, ec, ed, mul_a, add, acc, hs;
  logic signed [PT_W-1:0]  mul_b;
  logic signed [HW+PT_W-1:0] prod;
  logic signed [MW-1:0]    m;
  logic [MW-1:0]           mag, dinit, dtop;
  logic                    neg;
  logic [QB:0]             qq;
  logic signed [QB+1:0]    sv;
  logic signed [OUT_W-1:0] pt_ext, div_res;

  assign ea = HW'(a_r);
  assign eb = HW'(b_r);
  assign ec = HW'(c_r);
  assign ed = HW'(d_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    add   = '0;
    case (ctl.op)
      LANE_C1: begin
        mul_a = ed - ea + ec - eb;
        mul_b = PT_W'(ctl.tension);
        add   = (eb - ec) <<< 15;
      end
      LANE_C2: begin
        mul_a = (ea <<< 1) + eb - (ec <<< 1) - ed;
        mul_b = PT_W'(ctl.tension);
        add   = ((ec - eb) <<< 15) + ((ec - eb) <<< 14);
      end
      LANE_C3: begin
        mul_a = ec - ea;
        mul_b = PT_W'(ctl.tension);
      end
      LANE_K2: begin
        mul_a = c2_r;
        mul_b = PT_W'(ctl.grain);
      end
      LANE_K3: begin
        mul_a = c3_r;
        mul_b = PT_W'(ctl.g2);
      end
      LANE_K4: begin
        mul_a = (eb <<< 14) + HW'(512);
        mul_b = PT_W'(ctl.g3);
      end
      LANE_H0: begin
        mul_a = c1_r;
        mul_b = PT_W'(ctl.j);
        add   = k2_r;
      end
      LANE_H1: begin
        mul_a = h_r;
        mul_b = PT_W'(ctl.j);
        add   = k3_r;
      end
      LANE_H2: begin
        mul_a = h_r;
        mul_b = PT_W'(ctl.j);
        add   = k4_r;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign acc   = $signed(prod[HW-1:0]) + add;

  // floor by 1024, then magnitude for the divider
  assign hs    = h_r >>> 10;
  assign m     = hs[MW-1:0];
  assign neg   = m[MW-1];
  assign mag   = neg ? MW'(-m) : MW'(m);
  assign dinit = MW'(ctl.g3) << (QB - 1);
  assign dtop  = MW'(ctl.g3) << QB;

  always_ff @(posedge clk) begin
    case (ctl.op) inside
      LANE_LOAD: begin
        a_r <= pts_in.a;
        b_r <= pts_in.b;
        c_r <= pts_in.c;
        d_r <= pts_in.d;
      end
      LANE_C1: c1_r <= acc;
      LANE_C2: c2_r <= acc;
      LANE_C3: c3_r <= acc;
      LANE_K2: k2_r <= acc;
      LANE_K3: k3_r <= acc;
      LANE_K4: k4_r <= acc;
      LANE_H0, LANE_H1, LANE_H2: h_r <= acc;
      LANE_DINIT: begin
        rem_r <= mag;
        dsr_r <= dinit;
        q_r   <= '0;
        neg_r <= neg;
        ovf_r <= (mag >= dtop);
      end
      LANE_DSTEP: begin
        if (rem_r >= dsr_r) begin
          rem_r <= rem_r - dsr_r;
          q_r   <= {q_r[QB-2:0], 1'b1};
        end else begin
          q_r   <= {q_r[QB-2:0], 1'b0};
        end
        dsr_r <= dsr_r >> 1;
      end
      default: begin
      end
    endcase
  end

  // floor for negative quotients, then saturate
  assign qq = {1'b0, q_r} + (QB+1)'(neg_r && (rem_r != '0));
  assign sv = neg_r ? -$signed({1'b0, qq}) : $signed({1'b0, qq});

  always_comb begin
    if (ovf_r) begin
      div_res = neg_r ? OMIN : OMAX;
    end else if (sv > SMAX) begin
      div_res = OMAX;
    end else if (sv < SMIN) begin
      div_res = OMIN;
    end else begin
      div_res = sv[OUT_W-1:0];
    end
  end

  assign pt_ext = OUT_W'(b_r);
  assign res    = ctl.point ? (pt_ext <<< 4) : div_res;

endmodule

@@ design/cspl_back.sv @@
module cspl_back import cspl_pkg::*; #(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      jq_empty,
  input  job_t      jq_word,
  output logic      jq_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_word_t out_word
);

  localparam int GMAX   = (MAX_SAMPLES < GRAIN_CAP) ? MAX_SAMPLES : GRAIN_CAP;
  localparam int STEP_W = $clog2(QB);

  back_state_t        state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [SPS_W-1:0]   j_r, j_nxt, grain_r, grain;
  logic [10:0]        g2_r;
  logic [15:0]        g3_r;
  logic               point_r, last_r;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r;
  lane_op_t           op;
  lane_ctl_t          ctl;
  logic               out_load, seg_done;
  logic signed [OUT_W-1:0] res_x, res_y;

  always_comb begin
    if (cfg.samples == '0) begin
      grain = SPS_W'(1);
    end else if (cfg.samples > SPS_W'(GMAX)) begin
      grain = SPS_W'(GMAX);
    end else begin
      grain = cfg.samples;
    end
  end

  assign seg_done  = point_r || (j_r == grain_r);
  assign out_empty = !out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (!jq_empty) begin
        state_nxt = jq_word.point ? B_OUT : B_SETUP;
      end
      B_SETUP: if (step_r == STEP_W'(5)) begin
        state_nxt = B_HORN;
      end
      B_HORN:  if (step_r == STEP_W'(2)) begin
        state_nxt = B_DINIT;
      end
      B_DINIT: state_nxt = B_DIV;
      B_DIV:   if (step_r == STEP_W'(QB - 1)) begin
        state_nxt = B_OUT;
      end
      B_OUT:   if (out_load) begin
        state_nxt = seg_done ? B_IDLE : B_HORN;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    op       = LANE_HOLD;
    jq_pop   = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        jq_pop = !jq_empty;
        op     = jq_empty ? LANE_HOLD : LANE_LOAD;
      end
      B_SETUP: begin
        unique case (step_r)
          STEP_W'(0): op = LANE_C1;
          STEP_W'(1): op = LANE_C2;
          STEP_W'(2): op = LANE_C3;
          STEP_W'(3): op = LANE_K2;
          STEP_W'(4): op = LANE_K3;
          STEP_W'(5): op = LANE_K4;
          default:    op = LANE_HOLD;
        endcase
      end
      B_HORN: begin
        unique case (step_r)
          STEP_W'(0): op = LANE_H0;
          STEP_W'(1): op = LANE_H1;
          STEP_W'(2): op = LANE_H2;
          default:    op = LANE_HOLD;
        endcase
      end
      B_DINIT: op = LANE_DINIT;
      B_DIV:   op = LANE_DSTEP;
      B_OUT:   out_load = !out_valid_r || out_pop;
      default: op = LANE_HOLD;
    endcase
  end

  always_comb begin
    step_nxt = (state_nxt != state_r) ? '0 : step_r + 1'b1;
    j_nxt    = j_r;
    if (state_r == B_SETUP) begin
      j_nxt = SPS_W'(1);
    end else if (out_load && !seg_done) begin
      j_nxt = j_r + 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign ctl = '{op: op, point: point_r, tension: cfg.tension, j: j_r,
                 grain: grain_r, g2: g2_r, g3: g3_r};

  cspl_lane u_lane_x (
    .clk    (clk),
    .ctl    (ctl),
    .pts_in (jq_word.xp),
    .res    (res_x)
  );

  cspl_lane u_lane_y (
    .clk    (clk),
    .ctl    (ctl),
    .pts_in (jq_word.yp),
    .res    (res_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r <= j_nxt;
    if (jq_pop) begin
      point_r <= jq_word.point;
      last_r  <= jq_word.last;
      grain_r <= grain;
      g2_r    <= 11'(grain) * 11'(grain);
    end
    if (state_r == B_SETUP && step_r == '0) begin
      g3_r <= 16'(g2_r) * 16'(grain_r);
    end
    if (out_load) begin
      out_word_r.curve_x <= res_x;
      out_word_r.curve_y <= res_y;
      out_word_r.run_end <= last_r && seg_done;
    end
  end

`ifndef SYNTH
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (step_r < STEP_W'(QB)))
    else $error("divider ran past its quotient width");

  a_j_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_HORN) |-> (j_r >= SPS_W'(1) && j_r <= grain_r))
    else $error("sample index outside segment");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    jq_pop |-> (state_r == B_IDLE && !jq_empty))
    else $error("job taken while busy");
`endif

endmodule

@@ design/cardinal_spline_interpolator.sv @@
// channel  direction  handshake          word
// in       input      in_push / in_full  in_word (point_x, point_y, last_point)
// out      output     out_pop / out_empty out_word (curve_x, curve_y, run_end)
// cfg      input      cfg_we             cfg_index, cfg_data
// a point yields up to two segments; each segment starts with coefficient set-up
// and each sample takes 3 multiply-add, divider load, 21 divider steps and output
// the bit-serial divider by grain cubed sets the sample time
// synchronous reset, no clearing pass; the job queue lets the front take points ahead
// in_full is high while the front still hands jobs to the queue; a held output word stalls the back
module cardinal_spline_interpolator import cspl_pkg::*; #(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  in_word_t              in_word,
  output logic                  in_full,
  input  logic                  out_pop,
  output out_word_t             out_word,
  output logic                  out_empty,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r;
  logic jq_push, jq_full, jq_pop, jq_empty;
  job_t jq_in, jq_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tension <= DEF_TENSION;
      cfg_r.samples <= DEF_SAMPLES;
      cfg_r.reflect <= DEF_REFLECT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TENSION: cfg_r.tension <= cfg_data[TENS_W-1:0];
        CFG_SAMPLES: cfg_r.samples <= cfg_data[SPS_W-1:0];
        CFG_REFLECT: cfg_r.reflect <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  cspl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_word (in_word),
    .in_full (in_full),
    .reflect (cfg_r.reflect),
    .jq_push (jq_push),
    .jq_word (jq_in),
    .jq_full (jq_full)
  );

  cspl_jobq u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (jq_push),
    .push_word (jq_in),
    .full      (jq_full),
    .pop       (jq_pop),
    .head_word (jq_head),
    .empty     (jq_empty)
  );

  cspl_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .jq_empty  (jq_empty),
    .jq_word   (jq_head),
    .jq_pop    (jq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  import cspl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  in_word_t              in_word = '0;
  logic                  in_full;
  logic                  out_pop = 1'b0;
  out_word_t             out_word;
  logic                  out_empty;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TENSION;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cardinal_spline_interpolator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_word   (in_word),
    .in_full   (in_full),
    .out_pop   (out_pop),
    .out_word  (out_word),
    .out_empty (out_empty),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // expected curve words, oldest first
  out_word_t curve_q[$];
  int        err_cnt = 0;
  bit        steady = 1'b0;
  int        pop_hold = 0;

  // predictor copy of registers and point history
  longint    tension_r = 8192;
  longint    samples_r = 16;
  bit        reflect_r = 1'b0;
  longint    hist_x[3];
  longint    hist_y[3];
  int        seen = 0;

  initial begin
    forever #4ns clk = ~clk;
  end

  initial begin
    #60ms;
    $display("cardinal_spline_interpolator verification failed");
    $finish;
  end

  function automatic longint spline_coord(longint a, longint b, longint c, longint d,
                                          longint t, longint g, longint j);
    longint c1, c2, c3, g3, n, den, num, q;
    c1  = -t * a + (32768 - t) * b + (t - 32768) * c + t * d;
    c2  = 2 * t * a + (t - 49152) * b + (49152 - 2 * t) * c - t * d;
    c3  = -t * a + t * c;
    g3  = g * g * g;
    n   = b * 16384 * g3 + j * (c3 * g * g + j * (c2 * g + j * c1));
    den = 2 * 1024 * g3;
    num = 2 * n + 1024 * g3;
    q   = num / den;
    if ((num % den) != 0 && num < 0) q--;
    return q;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_q4(longint v);
    if (v > 524287) v = 524287;
    if (v < -524288) v = -524288;
    return v[OUT_W-1:0];
  endfunction

  function automatic void add_curve_word(longint x, longint y);
    out_word_t w;
    w.curve_x = clamp_q4(x);
    w.curve_y = clamp_q4(y);
    w.run_end = 1'b0;
    curve_q.insert(curve_q.size(), w);
  endfunction

  function automatic void add_segment(longint x0, longint x1, longint x2, longint x3,
                                      longint y0, longint y1, longint y2, longint y3);
    longint g;
    g = samples_r;
    if (g < 1) g = 1;
    if (g > 32) g = 32;
    for (longint j = 1; j <= g; j++)
      add_curve_word(spline_coord(x0, x1, x2, x3, tension_r, g, j),
                     spline_coord(y0, y1, y2, y3, tension_r, g, j));
  endfunction

  function automatic void predict_point(in_word_t w);
    longint x, y, ax, ay, bx, by;
    int     n0;
    bit     last;
    x    = longint'(w.point_x);
    y    = longint'(w.point_y);
    last = w.last_point;
    n0   = curve_q.size();
    if (seen == 1) begin
      ax = hist_x[2];
      ay = hist_y[2];
      add_curve_word(ax * 16, ay * 16);
      if (last) add_segment(ax, ax, x, x, ay, ay, y, y);
    end else if (seen == 2) begin
      ax = hist_x[1]; ay = hist_y[1];
      bx = hist_x[2]; by = hist_y[2];
      add_segment(reflect_r ? x + ax - bx : ax, ax, bx, x,
                  reflect_r ? y + ay - by : ay, ay, by, y);
      if (last) add_segment(ax, bx, x, reflect_r ? x - bx + ax : x,
                            ay, by, y, reflect_r ? y - by + ay : y);
    end else if (seen == 3) begin
      add_segment(hist_x[0], hist_x[1], hist_x[2], x, hist_y[0], hist_y[1], hist_y[2], y);
      if (last) begin
        ax = hist_x[1]; ay = hist_y[1];
        bx = hist_x[2]; by = hist_y[2];
        add_segment(ax, bx, x, reflect_r ? x - bx + ax : x,
                    ay, by, y, reflect_r ? y - by + ay : y);
      end
    end
    hist_x[0] = hist_x[1]; hist_x[1] = hist_x[2]; hist_x[2] = x;
    hist_y[0] = hist_y[1]; hist_y[1] = hist_y[2]; hist_y[2] = y;
    if (last) seen = 0;
    else if (seen < 3) seen++;
    if (curve_q.size() > n0) curve_q[$].run_end = 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side: check every popped word, then pick the next stall
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (curve_q.size() == 0) begin
        $error("unexpected curve word x=%0d y=%0d", out_word.curve_x, out_word.curve_y);
        err_cnt++;
      end else begin
        want = curve_q[0];
        curve_q.delete(0);
        if (out_word.curve_x !== want.curve_x) begin
          $error("curve_x expected %0d actual %0d", want.curve_x, out_word.curve_x);
          err_cnt++;
        end
        if (out_word.curve_y !== want.curve_y) begin
          $error("curve_y expected %0d actual %0d", want.curve_y, out_word.curve_y);
          err_cnt++;
        end
        if (out_word.run_end !== want.run_end) begin
          $error("run_end expected %0d actual %0d", want.run_end, out_word.run_end);
          err_cnt++;
        end
      end
    end
    if (pop_hold > 0) begin
      pop_hold--;
      out_pop <= 1'b0;
    end else begin
      pop_hold = pick_gap();
      out_pop <= (pop_hold == 0);
    end
  end

  task automatic send_point(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y, bit last);
    int gap;
    in_word_t w;
    w.point_x    = x;
    w.point_y    = y;
    w.last_point = last;
    in_push <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_full);
    predict_point(w);
    gap = pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (curve_q.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_TENSION: tension_r = longint'(val & 32'h7fff);
      CFG_SAMPLES: samples_r = longint'(val & 32'h3f);
      default:     reflect_r = val[0];
    endcase
  endtask

  task automatic set_regs(int unsigned t, int unsigned g, bit refl);
    drain();
    write_reg(CFG_TENSION, t);
    write_reg(CFG_SAMPLES, g);
    write_reg(CFG_REFLECT, 32'(refl));
  endtask

  function automatic logic signed [IN_W-1:0] rand_coord();
    int r;
    r = $urandom_range(99);
    if (r < 25) return IN_W'($urandom);
    if (r < 35) return r[0] ? 16'sh7fff : 16'sh8000;
    return IN_W'(int'($urandom_range(0, 400)) - 200);
  endfunction

  task automatic send_curve(int len);
    for (int i = 0; i < len; i++) send_point(rand_coord(), rand_coord(), i == len - 1);
  endtask

  task automatic test_default_regs();
    send_point(16'sd0, 16'sd0, 1'b1);
    send_point(16'sd10, -16'sd5, 1'b0);
    send_point(-16'sd3, 16'sd7, 1'b1);
    send_point(16'sh7fff, 16'sh8000, 1'b0);
    send_point(16'sh8000, 16'sh7fff, 1'b0);
    send_point(16'sh7fff, 16'sh7fff, 1'b1);
  endtask

  task automatic test_reg_extremes();
    set_regs(0, 1, 1'b1);
    send_curve(3);
    send_curve(4);
    set_regs(32767, 32, 1'b1);
    send_point(16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sh7fff, 16'sh7fff, 1'b0);
    send_point(16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sh7fff, 16'sh8000, 1'b1);
    set_regs(32767, 0, 1'b0);
    send_curve(4);
    set_regs(100, 63, 1'b1);
    send_curve(2);
    send_curve(5);
  endtask

  task automatic test_random_curves();
    int r, g, sent;
    for (int p = 0; p < 8; p++) begin
      r = $urandom_range(99);
      if (r < 70) g = $urandom_range(1, 6);
      else if (r < 90) g = $urandom_range(7, 31);
      else g = $urandom_range(0, 1) ? 0 : $urandom_range(32, 63);
      set_regs($urandom_range(0, 32767), g, 1'($urandom_range(0, 1)));
      steady = (p == 3);
      sent = 0;
      while (sent < 30) begin
        r = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 8);
        send_curve(r);
        sent += r;
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_regs();
    test_reg_extremes();
    test_random_curves();
    drain();
    if (err_cnt == 0)
      $display("cardinal_spline_interpolator verification clean");
    else
      $display("cardinal_spline_interpolator verification failed");
    $finish;
  end

endmodule
